// ----- sv/lcd_command_parser_window_writer_top_macros.svh -----
// ----------------------------------------------------------------------------
// LCD command parser assertion macros
// Shorthand for clocked implication checks, reset-qualified on arst_n.
// ----------------------------------------------------------------------------
`ifndef LCD_COMMAND_PARSER_WINDOW_WRITER_TOP_MACROS_SVH
`define LCD_COMMAND_PARSER_WINDOW_WRITER_TOP_MACROS_SVH

// same-cycle implication
`define LCPW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LCPW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/lcpw_pkg.sv -----
// ----------------------------------------------------------------------------
// LCD command parser package
// Display size, opcodes and the command length decoder.
// ----------------------------------------------------------------------------
package lcpw_pkg;

	// visible area of the panel, compared against 17-bit addresses
	localparam logic [16:0] DISPLAY_WIDTH  = 17'd160;
	localparam logic [16:0] DISPLAY_HEIGHT = 17'd128;

	// number of command bytes kept
	localparam int unsigned CMD_KEEP = 5;

	// opcodes with special handling
	localparam logic [7:0] OP_SWRESET = 8'h01;
	localparam logic [7:0] OP_CASET   = 8'h2A;
	localparam logic [7:0] OP_RASET   = 8'h2B;
	localparam logic [7:0] OP_RAMWR   = 8'h2C;

	// opcodes that only need their length known
	localparam logic [7:0] OP_MADCTL  = 8'h36;
	localparam logic [7:0] OP_COLMOD  = 8'h3A;
	localparam logic [7:0] OP_FRMCTR1 = 8'hB1;
	localparam logic [7:0] OP_FRMCTR2 = 8'hB2;
	localparam logic [7:0] OP_FRMCTR3 = 8'hB3;
	localparam logic [7:0] OP_INVCTR  = 8'hB4;
	localparam logic [7:0] OP_DISSET5 = 8'hB6;
	localparam logic [7:0] OP_PWCTR1  = 8'hC0;
	localparam logic [7:0] OP_PWCTR2  = 8'hC1;
	localparam logic [7:0] OP_PWCTR3  = 8'hC2;
	localparam logic [7:0] OP_PWCTR4  = 8'hC3;
	localparam logic [7:0] OP_PWCTR5  = 8'hC4;
	localparam logic [7:0] OP_VMCTR1  = 8'hC5;
	localparam logic [7:0] OP_GMCTRP1 = 8'hE0;
	localparam logic [7:0] OP_GMCTRN1 = 8'hE1;
	localparam logic [7:0] OP_PWCTR6  = 8'hFC;

	// highest byte count a command can reach
	localparam logic [4:0] MAX_CMD_LEN = 5'd17;

	// bytes per command, opcode included; unknown opcodes take one byte
	function automatic logic [4:0] cmd_length(input logic [7:0] op);
		logic [4:0] len;
		unique case (op) inside
			OP_COLMOD, OP_MADCTL, OP_INVCTR, OP_PWCTR2: len = 5'd2;
			OP_DISSET5, OP_PWCTR1, OP_PWCTR3, OP_PWCTR4,
			OP_PWCTR5, OP_PWCTR6, OP_VMCTR1: len = 5'd3;
			OP_FRMCTR1, OP_FRMCTR2: len = 5'd4;
			OP_CASET, OP_RASET: len = 5'd5;
			OP_FRMCTR3: len = 5'd7;
			OP_GMCTRP1, OP_GMCTRN1: len = MAX_CMD_LEN;
			default: len = 5'd1;
		endcase
		return len;
	endfunction

endpackage

// ----- sv/lcd_command_parser_window_writer_top.sv -----
// ----------------------------------------------------------------------------
// LCD command parser and window writer
// Parses serial command bytes, tracks the drawing window and turns pixel
// data into frame memory writes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: data_byte with in_valid / in_stall, one serial byte per
//   transaction. Output channel: one result transaction per input byte with
//   pixel_write, pixel_column, pixel_row, pixel_colour and the status flags
//   row_done, window_done, frame_clear, command_done, on out_valid / out_stall.
//   An accepted byte lands in the input register, is decoded against the
//   parser state and is written to the result register once that register
//   is free or being drained. Throughput is one byte per cycle while the
//   receiver does not stall, set by the state update (byte counter compare,
//   address increment and wrap compare).
//   When the receiver stalls, the result register holds and the input
//   register still takes one more byte; in_stall rises only when both hold.
//   Reset clears the parser state, the window and pixel mode, and empties both
//   registers. A SWRESET opcode does the same to the parser state and reports
//   frame_clear so the frame memory can be zeroed outside this block.
// ----------------------------------------------------------------------------
`include "lcd_command_parser_window_writer_top_macros.svh"

module lcd_command_parser_window_writer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        pixel_write,
	output logic [7:0]  pixel_column,
	output logic [6:0]  pixel_row,
	output logic [15:0] pixel_colour,
	output logic        row_done,
	output logic        window_done,
	output logic        frame_clear,
	output logic        command_done
);

	// input register
	logic       valid_s1;
	logic [7:0] data_s1;

	// parser state
	logic [7:0]  cmd_bytes_q [lcpw_pkg::CMD_KEEP];
	logic [4:0]  byte_count_q;
	logic [15:0] col_start_q, col_end_q, row_start_q, row_end_q;
	logic [15:0] col_addr_q;
	logic [16:0] row_addr_q;
	logic        pixel_mode_q;

	// result register
	logic        out_valid_q;
	logic        wr_q, rdone_q, wdone_q, fclear_q, done_q;
	logic [7:0]  col_q;
	logic [6:0]  row_q;
	logic [15:0] colour_q;

	// next values
	logic [7:0]  cur_byte [lcpw_pkg::CMD_KEEP];
	logic [7:0]  op;
	logic [4:0]  cnt_inc;
	logic        advance;
	logic        done_d, wr_d, rdone_d, wdone_d, fclear_d;
	logic [7:0]  col_d;
	logic [6:0]  row_d;
	logic [15:0] colour_d;
	logic [4:0]  byte_count_d;
	logic [15:0] col_start_d, col_end_d, row_start_d, row_end_d;
	logic [15:0] col_addr_d;
	logic [16:0] row_addr_d;
	logic [16:0] row_next;
	logic        pixel_mode_d;

	// handshake: process when the result register is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// command bytes as seen with the current byte merged in
	always_comb begin
		for (int i = 0; i < lcpw_pkg::CMD_KEEP; i++) begin
			cur_byte[i] = (byte_count_q == 5'(i)) ? data_s1 : cmd_bytes_q[i];
		end
	end

	assign op       = cur_byte[0];
	assign cnt_inc  = byte_count_q + 5'd1;
	assign row_next = row_addr_q + 17'd1;

	// parser and window walk
	always_comb begin
		done_d       = 1'b0;
		wr_d         = 1'b0;
		rdone_d      = 1'b0;
		wdone_d      = 1'b0;
		fclear_d     = 1'b0;
		col_d        = '0;
		row_d        = '0;
		colour_d     = '0;
		col_start_d  = col_start_q;
		col_end_d    = col_end_q;
		row_start_d  = row_start_q;
		row_end_d    = row_end_q;
		col_addr_d   = col_addr_q;
		row_addr_d   = row_addr_q;
		pixel_mode_d = pixel_mode_q;
		if (pixel_mode_q) begin
			done_d = (cnt_inc >= 5'd2);
			if (done_d) begin
				if (({1'b0, col_addr_q} < lcpw_pkg::DISPLAY_WIDTH) &&
				    (row_addr_q < lcpw_pkg::DISPLAY_HEIGHT)) begin
					wr_d     = 1'b1;
					col_d    = col_addr_q[7:0];
					row_d    = row_addr_q[6:0];
					colour_d = {cur_byte[0], cur_byte[1]};
				end
				// column step past the end wraps to the next row
				if (col_addr_q >= col_end_q) begin
					rdone_d    = 1'b1;
					col_addr_d = col_start_q;
					row_addr_d = row_next;
					if (row_next > {1'b0, row_end_q}) begin
						pixel_mode_d = 1'b0;
						wdone_d      = 1'b1;
					end
				end else begin
					col_addr_d = col_addr_q + 16'd1;
				end
			end
		end else begin
			done_d = (cnt_inc >= lcpw_pkg::cmd_length(op));
			if (op == lcpw_pkg::OP_SWRESET) begin
				fclear_d     = 1'b1;
				done_d       = 1'b1;
				col_start_d  = '0;
				col_end_d    = '0;
				row_start_d  = '0;
				row_end_d    = '0;
				col_addr_d   = '0;
				row_addr_d   = '0;
				pixel_mode_d = 1'b0;
			end else if (op == lcpw_pkg::OP_RAMWR) begin
				col_addr_d   = col_start_q;
				row_addr_d   = {1'b0, row_start_q};
				pixel_mode_d = 1'b1;
			end else if (done_d && op == lcpw_pkg::OP_CASET) begin
				col_start_d = {cur_byte[1], cur_byte[2]};
				col_end_d   = {cur_byte[3], cur_byte[4]};
			end else if (done_d && op == lcpw_pkg::OP_RASET) begin
				row_start_d = {cur_byte[1], cur_byte[2]};
				row_end_d   = {cur_byte[3], cur_byte[4]};
			end
		end
		byte_count_d = done_d ? 5'd0 : cnt_inc;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			data_s1 <= data_byte;
		end
	end

	// kept command bytes, no reset needed
	always_ff @(posedge clk) begin
		if (advance && byte_count_q < 5'(lcpw_pkg::CMD_KEEP)) begin
			cmd_bytes_q[byte_count_q[2:0]] <= data_s1;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			col_start_q  <= '0;
			col_end_q    <= '0;
			row_start_q  <= '0;
			row_end_q    <= '0;
			col_addr_q   <= '0;
			row_addr_q   <= '0;
			pixel_mode_q <= 1'b0;
		end else if (advance) begin
			byte_count_q <= byte_count_d;
			col_start_q  <= col_start_d;
			col_end_q    <= col_end_d;
			row_start_q  <= row_start_d;
			row_end_q    <= row_end_d;
			col_addr_q   <= col_addr_d;
			row_addr_q   <= row_addr_d;
			pixel_mode_q <= pixel_mode_d;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			wr_q     <= wr_d;
			col_q    <= col_d;
			row_q    <= row_d;
			colour_q <= colour_d;
			rdone_q  <= rdone_d;
			wdone_q  <= wdone_d;
			fclear_q <= fclear_d;
			done_q   <= done_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_write  = wr_q;
	assign pixel_column = col_q;
	assign pixel_row    = row_q;
	assign pixel_colour = colour_q;
	assign row_done     = rdone_q;
	assign window_done  = wdone_q;
	assign frame_clear  = fclear_q;
	assign command_done = done_q;

	// checks
	`LCPW_ASSERT_NOW(a_write_done, out_valid_q && (wr_q || rdone_q), done_q, "pixel without done")
	`LCPW_ASSERT_NOW(a_window_row, out_valid_q && wdone_q, rdone_q, "window_done without row_done")
	`LCPW_ASSERT_NOW(a_count_max, 1'b1, byte_count_q <= lcpw_pkg::MAX_CMD_LEN, "count too high")
	`LCPW_ASSERT_NEXT(a_swreset_clear, advance && fclear_d, byte_count_q == '0, "count kept")
	`LCPW_ASSERT_NEXT(a_window_exit, advance && wdone_d, !pixel_mode_q, "pixel mode kept")

endmodule

// ----- tb/sv/lcpw_pixel_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LCD command parser result checker
// Watches both channels of the parser. Every accepted serial byte runs
// through a predictor of the parser state, and the expected result is
// queued. Every accepted result is compared field by field against the
// oldest queued one. Mismatches and progress counts go back to the top.
// ----------------------------------------------------------------------------
module lcpw_pixel_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        pixel_write,
	input  logic [7:0]  pixel_column,
	input  logic [6:0]  pixel_row,
	input  logic [15:0] pixel_colour,
	input  logic        row_done,
	input  logic        window_done,
	input  logic        frame_clear,
	input  logic        command_done,
	output int          mismatches,
	output int          pending,
	output int          results_seen,
	output int          writes_seen,
	output int          windows_seen,
	output int          clears_seen
);

	typedef struct packed {
		logic        pixel_write;
		logic [7:0]  pixel_column;
		logic [6:0]  pixel_row;
		logic [15:0] pixel_colour;
		logic        row_done;
		logic        window_done;
		logic        frame_clear;
		logic        command_done;
	} pixel_result_t;

	// predicted parser state
	logic [7:0]  cmd_buf [lcpw_pkg::CMD_KEEP];
	logic [4:0]  byte_cnt;
	logic [15:0] col_lo, col_hi, row_lo, row_hi;
	logic [15:0] col_ptr;
	logic [16:0] row_ptr;
	logic        drawing;

	pixel_result_t result_q [$];

	// bytes per command including the opcode
	function automatic logic [4:0] cmd_span(input logic [7:0] op);
		case (op) inside
			lcpw_pkg::OP_COLMOD, lcpw_pkg::OP_MADCTL, lcpw_pkg::OP_INVCTR,
			lcpw_pkg::OP_PWCTR2: return 5'd2;
			lcpw_pkg::OP_DISSET5, lcpw_pkg::OP_PWCTR1, lcpw_pkg::OP_PWCTR3,
			lcpw_pkg::OP_PWCTR4, lcpw_pkg::OP_PWCTR5, lcpw_pkg::OP_PWCTR6,
			lcpw_pkg::OP_VMCTR1: return 5'd3;
			lcpw_pkg::OP_FRMCTR1, lcpw_pkg::OP_FRMCTR2: return 5'd4;
			lcpw_pkg::OP_CASET, lcpw_pkg::OP_RASET: return 5'd5;
			lcpw_pkg::OP_FRMCTR3: return 5'd7;
			lcpw_pkg::OP_GMCTRP1, lcpw_pkg::OP_GMCTRN1: return 5'd17;
			default: return 5'd1;
		endcase
	endfunction

	// power-on and software reset state
	task automatic clear_state();
		for (int i = 0; i < lcpw_pkg::CMD_KEEP; i++)
			cmd_buf[i] = 8'h00;
		byte_cnt = '0;
		col_lo = '0;
		col_hi = '0;
		row_lo = '0;
		row_hi = '0;
		col_ptr = '0;
		row_ptr = '0;
		drawing = 1'b0;
	endtask

	// advance the parser by one serial byte and return its result
	task automatic parse_byte(input logic [7:0] b, output pixel_result_t r);
		logic [7:0] op;
		logic       done;
		r = '0;
		if (byte_cnt < 5'(lcpw_pkg::CMD_KEEP))
			cmd_buf[byte_cnt[2:0]] = b;
		byte_cnt = byte_cnt + 5'd1;
		if (drawing) begin
			// pixel data: two bytes per colour, step across the window
			done = (byte_cnt >= 5'd2);
			if (done) begin
				if ({1'b0, col_ptr} < lcpw_pkg::DISPLAY_WIDTH &&
				    row_ptr < lcpw_pkg::DISPLAY_HEIGHT) begin
					r.pixel_write = 1'b1;
					r.pixel_column = col_ptr[7:0];
					r.pixel_row = row_ptr[6:0];
					r.pixel_colour = {cmd_buf[0], cmd_buf[1]};
				end
				if ({1'b0, col_ptr} + 17'd1 > {1'b0, col_hi}) begin
					r.row_done = 1'b1;
					col_ptr = col_lo;
					row_ptr = row_ptr + 17'd1;
					if (row_ptr > {1'b0, row_hi}) begin
						drawing = 1'b0;
						r.window_done = 1'b1;
					end
				end else begin
					col_ptr = col_ptr + 16'd1;
				end
			end
		end else begin
			// command collection
			op = cmd_buf[0];
			done = (byte_cnt >= cmd_span(op));
			if (op == lcpw_pkg::OP_SWRESET) begin
				clear_state();
				r.frame_clear = 1'b1;
				done = 1'b1;
			end else if (op == lcpw_pkg::OP_RAMWR) begin
				col_ptr = col_lo;
				row_ptr = {1'b0, row_lo};
				drawing = 1'b1;
			end else if (done && op == lcpw_pkg::OP_CASET) begin
				col_lo = {cmd_buf[1], cmd_buf[2]};
				col_hi = {cmd_buf[3], cmd_buf[4]};
			end else if (done && op == lcpw_pkg::OP_RASET) begin
				row_lo = {cmd_buf[1], cmd_buf[2]};
				row_hi = {cmd_buf[3], cmd_buf[4]};
			end
		end
		if (done)
			byte_cnt = '0;
		r.command_done = done;
	endtask

	task automatic compare_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	// sample both channels at the rising edge
	always @(posedge clk or negedge arst_n) begin : monitor
		pixel_result_t want;
		pixel_result_t next_result;
		if (!arst_n) begin
			clear_state();
			result_q.delete();
			mismatches = 0;
			pending = 0;
			results_seen = 0;
			writes_seen = 0;
			windows_seen = 0;
			clears_seen = 0;
		end else begin
			// result transaction against the oldest expectation
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					$error("result transaction with no expectation pending");
					mismatches++;
				end else begin
					want = result_q.pop_front();
					results_seen++;
					if (want.pixel_write)
						writes_seen++;
					if (want.window_done)
						windows_seen++;
					if (want.frame_clear)
						clears_seen++;
					compare_field("pixel_write", 16'(want.pixel_write), 16'(pixel_write));
					compare_field("pixel_column", 16'(want.pixel_column), 16'(pixel_column));
					compare_field("pixel_row", 16'(want.pixel_row), 16'(pixel_row));
					compare_field("pixel_colour", want.pixel_colour, pixel_colour);
					compare_field("row_done", 16'(want.row_done), 16'(row_done));
					compare_field("window_done", 16'(want.window_done), 16'(window_done));
					compare_field("frame_clear", 16'(want.frame_clear), 16'(frame_clear));
					compare_field("command_done", 16'(want.command_done), 16'(command_done));
				end
			end
			// input transaction: predict its result
			if (in_valid && !in_stall) begin
				parse_byte(data_byte, next_result);
				result_q.push_back(next_result);
			end
			pending = result_q.size();
		end
	end

endmodule

// ----- tb/sv/lcd_command_parser_window_writer_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LCD command parser and window writer testbench
// Feeds the parser a short directed byte stream (window setup across the
// display edge, start beyond end, pixel data at the byte extremes, software
// reset) and then random command streams: window commands, frame writes that
// fill the whole window, filler and long commands, unknown opcodes and
// software resets. Both sides idle at random, but not in the last of three
// phases. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module lcd_command_parser_window_writer_top_test;

	localparam int BYTE_TARGET  = 1000;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 8;

	// directed stream: edge window, start beyond end window, software reset
	localparam logic [7:0] DIRECTED_BYTES [25] = '{
		lcpw_pkg::OP_SWRESET,
		lcpw_pkg::OP_CASET, 8'h00, 8'h9F, 8'h00, 8'hA0,
		lcpw_pkg::OP_RASET, 8'h00, 8'h7F, 8'h00, 8'h7F,
		lcpw_pkg::OP_RAMWR, 8'hFF, 8'hFF, 8'h00, 8'h00,
		lcpw_pkg::OP_CASET, 8'h00, 8'h05, 8'h00, 8'h03,
		lcpw_pkg::OP_RAMWR, 8'h5A, 8'hA5,
		lcpw_pkg::OP_SWRESET
	};

	// opcodes with parameters, used as filler
	localparam logic [7:0] FILLER_OPS [16] = '{
		lcpw_pkg::OP_COLMOD, lcpw_pkg::OP_MADCTL, lcpw_pkg::OP_INVCTR,
		lcpw_pkg::OP_PWCTR2, lcpw_pkg::OP_DISSET5, lcpw_pkg::OP_PWCTR1,
		lcpw_pkg::OP_PWCTR3, lcpw_pkg::OP_PWCTR4, lcpw_pkg::OP_PWCTR5,
		lcpw_pkg::OP_PWCTR6, lcpw_pkg::OP_VMCTR1, lcpw_pkg::OP_FRMCTR1,
		lcpw_pkg::OP_FRMCTR2, lcpw_pkg::OP_FRMCTR3, lcpw_pkg::OP_GMCTRP1,
		lcpw_pkg::OP_GMCTRN1
	};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        pixel_write;
	logic [7:0]  pixel_column;
	logic [6:0]  pixel_row;
	logic [15:0] pixel_colour;
	logic        row_done;
	logic        window_done;
	logic        frame_clear;
	logic        command_done;

	int mismatches, pending, results_seen, writes_seen, windows_seen, clears_seen;
	int send_idle_pct = 17;
	int recv_idle_pct = 75;
	int bytes_sent = 0;
	int cycle_count = 0;

	// window as last programmed, to size each frame write
	logic [15:0] col_lo_sh = '0, col_hi_sh = '0, row_lo_sh = '0, row_hi_sh = '0;

	lcd_command_parser_window_writer_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_write  (pixel_write),
		.pixel_column (pixel_column),
		.pixel_row    (pixel_row),
		.pixel_colour (pixel_colour),
		.row_done     (row_done),
		.window_done  (window_done),
		.frame_clear  (frame_clear),
		.command_done (command_done)
	);

	lcpw_pixel_checker pixel_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_write  (pixel_write),
		.pixel_column (pixel_column),
		.pixel_row    (pixel_row),
		.pixel_colour (pixel_colour),
		.row_done     (row_done),
		.window_done  (window_done),
		.frame_clear  (frame_clear),
		.command_done (command_done),
		.mismatches   (mismatches),
		.pending      (pending),
		.results_seen (results_seen),
		.writes_seen  (writes_seen),
		.windows_seen (windows_seen),
		.clears_seen  (clears_seen)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// receiver stalls at random
	always @(negedge clk) begin
		out_stall <= arst_n && ($urandom_range(99) < recv_idle_pct);
	end

	// one byte transaction; entered and left at a falling edge
	task automatic send_byte(input logic [7:0] b);
		if (bytes_sent < BYTE_TARGET / 3) begin
			send_idle_pct = 17;
			recv_idle_pct = 75;
		end else if (bytes_sent < 2 * BYTE_TARGET / 3) begin
			send_idle_pct = 75;
			recv_idle_pct = 17;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
		// sender idles cycle by cycle
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		do
			@(posedge clk);
		while (in_stall);
		bytes_sent++;
		@(negedge clk);
	endtask

	// parameter or pixel byte, sometimes carrying an opcode value
	function automatic logic [7:0] rand_payload();
		case ($urandom_range(0, 15))
			0: return lcpw_pkg::OP_SWRESET;
			1: return lcpw_pkg::OP_CASET;
			2: return lcpw_pkg::OP_RAMWR;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// small window span: inside the display, across its edge, up against
	// 0xFFFF, or with start beyond end
	task automatic pick_span(output logic [15:0] lo, output logic [15:0] hi);
		logic [15:0] a, b;
		case ($urandom_range(0, 4))
			0: begin
				lo = 16'($urandom_range(0, 160));
				hi = lo + 16'($urandom_range(0, 7));
			end
			1: begin
				lo = 16'($urandom_range(120, 170));
				hi = lo + 16'($urandom_range(0, 7));
			end
			2: begin
				lo = 16'($urandom_range(16'hFFF8, 16'hFFFF));
				hi = 16'hFFFF;
			end
			3: begin
				a = 16'($urandom_range(0, 65535));
				b = 16'($urandom_range(0, 65535));
				lo = (a > b) ? a : b;
				hi = (a > b) ? b : a;
			end
			default: begin
				lo = 16'($urandom_range(0, 3));
				hi = lo + 16'($urandom_range(0, 3));
			end
		endcase
	endtask

	// column or row window command
	task automatic send_window(input logic [7:0] op);
		logic [15:0] lo, hi;
		pick_span(lo, hi);
		send_byte(op);
		send_byte(lo[15:8]);
		send_byte(lo[7:0]);
		send_byte(hi[15:8]);
		send_byte(hi[7:0]);
		if (op == lcpw_pkg::OP_CASET) begin
			col_lo_sh = lo;
			col_hi_sh = hi;
		end else begin
			row_lo_sh = lo;
			row_hi_sh = hi;
		end
	endtask

	// memory write followed by pixel data for the whole window
	task automatic send_frame();
		int cols, rows;
		cols = (col_lo_sh > col_hi_sh) ? 1 : int'(col_hi_sh - col_lo_sh) + 1;
		rows = (row_lo_sh > row_hi_sh) ? 1 : int'(row_hi_sh - row_lo_sh) + 1;
		send_byte(lcpw_pkg::OP_RAMWR);
		repeat (2 * cols * rows)
			send_byte(rand_payload());
	endtask

	// complete command with random parameters
	task automatic send_filler();
		logic [7:0] op;
		op = FILLER_OPS[$urandom_range(0, 15)];
		send_byte(op);
		repeat (int'(lcpw_pkg::cmd_length(op)) - 1)
			send_byte(rand_payload());
	endtask

	// single-byte opcode with no effect on the window
	task automatic send_unknown();
		logic [7:0] op;
		do
			op = 8'($urandom_range(0, 255));
		while (lcpw_pkg::cmd_length(op) != 5'd1 || op == lcpw_pkg::OP_SWRESET ||
		       op == lcpw_pkg::OP_RAMWR);
		send_byte(op);
	endtask

	// stimulus
	initial begin
		int pick;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed stream ends in a software reset, window back to zero
		foreach (DIRECTED_BYTES[i])
			send_byte(DIRECTED_BYTES[i]);

		// random command streams
		while (bytes_sent < BYTE_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 18)
				send_window(lcpw_pkg::OP_CASET);
			else if (pick < 36)
				send_window(lcpw_pkg::OP_RASET);
			else if (pick < 70)
				send_frame();
			else if (pick < 86)
				send_filler();
			else if (pick < 96)
				send_unknown();
			else begin
				send_byte(lcpw_pkg::OP_SWRESET);
				col_lo_sh = '0;
				col_hi_sh = '0;
				row_lo_sh = '0;
				row_hi_sh = '0;
			end
		end
		in_valid <= 1'b0;

		// drain
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("sent %0d serial bytes, checked %0d results", bytes_sent, results_seen);
		$display("saw %0d pixel writes, %0d finished windows, %0d frame clears",
			writes_seen, windows_seen, clears_seen);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+sv
sv/lcpw_pkg.sv
sv/lcd_command_parser_window_writer_top.sv
tb/sv/lcpw_pixel_checker.sv
tb/sv/lcd_command_parser_window_writer_top_test.sv
